>>> design/timer_table_periodic_oneshot_core_defines.svh
// Assertion macros for the timer table core.
`ifndef TIMER_TABLE_PERIODIC_ONESHOT_CORE_DEFINES_SVH
`define TIMER_TABLE_PERIODIC_ONESHOT_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TTPO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TTPO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ttpo_pkg.sv
package ttpo_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);

	localparam int TIME_W = 40;
	localparam int ID_W = 4;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 3;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK = 2'd0,
		MODE_REG_PERIODIC = 2'd1,
		MODE_REG_ONESHOT = 2'd2,
		MODE_UNREG = 2'd3
	} mode_t;

	localparam logic [STATUS_W-1:0] STATUS_FIRED = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NONE_FIRED = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_REGISTERED = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_REMOVED = 3'd4;
	localparam logic [STATUS_W-1:0] STATUS_NOT_ACTIVE = 3'd5;

endpackage

>>> design/timer_table_periodic_oneshot_core.sv
// Tick: every slot is scanned and a last result word ends it, after the top slot's compare if
// that slot is active; busy throughout. One table entry is read per cycle into a single comparator.
// Register: one slot is checked per cycle for the lowest free one.
// Unregister: result in the cycle after start, busy stays low, so it sustains one per cycle.
// Results are shown for one cycle under done; the receiver cannot stall.
// Reset (arst_n low, asynchronous) frees every slot and returns the sequencer to idle.
`include "timer_table_periodic_oneshot_core_defines.svh"

module timer_table_periodic_oneshot_core
	import ttpo_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MODE_W-1:0]   mode,
	input  logic [TIME_W-1:0]   now_time,
	input  logic [TIME_W-1:0]   duration,
	input  logic [ID_W-1:0]     timer_id,
	output logic                done,
	output logic [ID_W-1:0]     timer_id_res,
	output logic [STATUS_W-1:0] status,
	output logic                last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_TICK,
		S_REG
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [NUM_SLOTS-1:0]   active_q;
	logic [TIME_W-1:0]      now_q;
	logic [TIME_W-1:0]      dur_q;
	logic                   oneshot_q;
	logic                   pend_vld_q;
	logic [SLOT_W-1:0]      pend_id_q;

	logic                   ev_vld_s1;
	logic [SLOT_W-1:0]      ev_idx_s1;
	logic [TIME_W-1:0]      rd_start_s1;
	logic [TIME_W-1:0]      rd_period_s1;
	logic                   rd_oneshot_s1;

	logic [TIME_W-1:0]      mem_start [NUM_SLOTS];
	logic [TIME_W-1:0]      mem_period [NUM_SLOTS];
	logic                   mem_oneshot [NUM_SLOTS];

	logic [SLOT_W-1:0]      scan_idx;
	logic                   scan_end;
	logic [TIME_W-1:0]      elapsed;
	logic                   fire;
	logic                   accept;
	logic                   tid_ok;
	logic [SLOT_W-1:0]      tid_slot;
	logic                   we_start;
	logic                   we_all;
	logic [SLOT_W-1:0]      wr_addr;
	logic [TIME_W-1:0]      wr_start;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign scan_idx = cnt_q[SLOT_W-1:0];
	assign scan_end = (cnt_q == CNT_W'(NUM_SLOTS));
	assign elapsed  = now_q - rd_start_s1;
	assign fire     = ev_vld_s1 && (elapsed >= rd_period_s1);
	assign tid_slot = SLOT_W'(timer_id);
	assign tid_ok   = (int'(timer_id) < NUM_SLOTS) && active_q[tid_slot];

	// The table takes one write per cycle: a new registration, or a periodic slot
	// advancing its start after it fired.
	always_comb begin
		we_start = 1'b0;
		we_all   = 1'b0;
		wr_addr  = scan_idx;
		wr_start = now_q;
		if (state_q == S_REG && !scan_end && !active_q[scan_idx]) begin
			we_all = 1'b1;
		end else if (state_q == S_TICK && fire && !rd_oneshot_s1) begin
			we_start = 1'b1;
			wr_addr  = ev_idx_s1;
			wr_start = rd_start_s1 + rd_period_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (we_all || we_start) begin
			mem_start[wr_addr] <= wr_start;
		end
		if (we_all) begin
			mem_period[wr_addr]  <= dur_q;
			mem_oneshot[wr_addr] <= oneshot_q;
		end
		rd_start_s1   <= mem_start[scan_idx];
		rd_period_s1  <= mem_period[scan_idx];
		rd_oneshot_s1 <= mem_oneshot[scan_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			active_q     <= '0;
			now_q        <= '0;
			dur_q        <= '0;
			oneshot_q    <= 1'b0;
			pend_vld_q   <= 1'b0;
			pend_id_q    <= '0;
			ev_vld_s1    <= 1'b0;
			ev_idx_s1    <= '0;
			done         <= 1'b0;
			timer_id_res <= '0;
			status       <= STATUS_NONE_FIRED;
			last         <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					ev_vld_s1 <= 1'b0;
					if (accept) begin
						now_q      <= now_time;
						dur_q      <= duration;
						oneshot_q  <= (mode_t'(mode) == MODE_REG_ONESHOT);
						cnt_q      <= '0;
						pend_vld_q <= 1'b0;
						case (mode_t'(mode))
							MODE_TICK: begin
								state_q <= S_TICK;
							end
							MODE_REG_PERIODIC, MODE_REG_ONESHOT: begin
								state_q <= S_REG;
							end
							MODE_UNREG: begin
								done         <= 1'b1;
								last         <= 1'b1;
								timer_id_res <= timer_id;
								if (tid_ok) begin
									active_q[tid_slot] <= 1'b0;
									status             <= STATUS_REMOVED;
								end else begin
									status <= STATUS_NOT_ACTIVE;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_TICK: begin
					if (!scan_end) begin
						ev_vld_s1 <= active_q[scan_idx];
						ev_idx_s1 <= scan_idx;
						cnt_q     <= cnt_q + 1'b1;
					end else begin
						ev_vld_s1 <= 1'b0;
					end
					// A fired slot is held back one step so that last can be set on
					// the final one.
					if (fire) begin
						pend_vld_q <= 1'b1;
						pend_id_q  <= ev_idx_s1;
						if (rd_oneshot_s1) begin
							active_q[ev_idx_s1] <= 1'b0;
						end
						if (pend_vld_q) begin
							done         <= 1'b1;
							last         <= 1'b0;
							status       <= STATUS_FIRED;
							timer_id_res <= ID_W'(pend_id_q);
						end
					end
					if (scan_end && !ev_vld_s1) begin
						state_q <= S_IDLE;
						done    <= 1'b1;
						last    <= 1'b1;
						if (pend_vld_q) begin
							status       <= STATUS_FIRED;
							timer_id_res <= ID_W'(pend_id_q);
						end else begin
							status       <= STATUS_NONE_FIRED;
							timer_id_res <= '0;
						end
					end
				end
				S_REG: begin
					if (scan_end) begin
						state_q      <= S_IDLE;
						done         <= 1'b1;
						last         <= 1'b1;
						status       <= STATUS_FULL;
						timer_id_res <= '0;
					end else if (!active_q[scan_idx]) begin
						active_q[scan_idx] <= 1'b1;
						state_q            <= S_IDLE;
						done               <= 1'b1;
						last               <= 1'b1;
						status             <= STATUS_REGISTERED;
						timer_id_res       <= ID_W'(scan_idx);
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TTPO_ASSERT_NOW(a_more_words_follow, done && !last, busy, "word without last while idle")
	`TTPO_ASSERT_NOW(a_idle_stage_empty, state_q == S_IDLE, !ev_vld_s1, "scan stage occupied in idle")
	`TTPO_ASSERT_NEXT(a_tick_goes_busy, accept && mode_t'(mode) == MODE_TICK, busy, "tick not started")
	`TTPO_ASSERT_NOW(a_fire_only_in_tick, fire, state_q == S_TICK, "slot evaluated outside a tick")

endmodule
